FILE: sv/ske_pkg.sv
// Shared types and constants for the sample excess kurtosis block.
// Used by the front end, back end, top level and checker; depends on nothing else.
package ske_pkg;

  localparam int unsigned MaxSamplesDef = 1024;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned ResW          = 32;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] kurt;
    logic [ResW-1:0]        std_dev;
    logic                   error;
  } out_item_t;

endpackage

FILE: sv/ske_front.sv
// Front end: takes samples, stores them, keeps the count and the running sum,
// and hands a finished series to the back end. Depends on ske_pkg.
module ske_front #(
  parameter int unsigned MAX_SAMPLES = ske_pkg::MaxSamplesDef,
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AddrW = $clog2(MAX_SAMPLES),
  localparam int unsigned SumW  = ske_pkg::SampleW + CntW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  ske_pkg::in_item_t                 in_item_i,
  output logic                              full_o,
  input  logic [AddrW-1:0]                  rd_addr_i,
  output logic signed [ske_pkg::SampleW-1:0] rd_data_o,
  output logic                              job_push_o,
  output logic [CntW-1:0]                   job_n_o,
  output logic signed [SumW-1:0]            job_s_o,
  input  logic                              job_full_i,
  input  logic                              release_i
);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic                   busy_q, busy_d;
  logic                   accept, wr;
  logic [CntW-1:0]        cnt_wr;
  logic signed [SumW-1:0] sum_wr;

  logic signed [ske_pkg::SampleW-1:0] mem [MAX_SAMPLES];
  logic signed [ske_pkg::SampleW-1:0] rd_q;

  assign full_o = busy_q || job_full_i;
  assign accept = push_i && !full_o;
  // Samples past the end of the store are dropped, but their last mark counts.
  assign wr     = accept && (cnt_q < CntW'(MAX_SAMPLES));
  assign cnt_wr = wr ? cnt_q + 1'b1 : cnt_q;
  assign sum_wr = wr ? sum_q + SumW'(in_item_i.sample) : sum_q;

  assign job_push_o = accept && in_item_i.last;
  assign job_n_o    = cnt_wr;
  assign job_s_o    = sum_wr;
  assign rd_data_o  = rd_q;

  always_comb begin
    cnt_d  = cnt_wr;
    sum_d  = sum_wr;
    busy_d = busy_q;
    if (job_push_o) begin
      cnt_d  = '0;
      sum_d  = '0;
      busy_d = 1'b1;
    end
    if (release_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[cnt_q[AddrW-1:0]] <= in_item_i.sample;
    end
    rd_q <= mem[rd_addr_i];
  end

endmodule

FILE: sv/ske_fifo.sv
// Two-entry queue that carries finished series descriptors from the front
// end to the back end. Self-contained.
module ske_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         empty_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   fill_q;
  logic         do_push, do_pop;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/ske_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of
// the back end. Self-contained.
module ske_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32,
  localparam int unsigned StepW = $clog2(NumW + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DenW-1:0]  rem_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [StepW-1:0] steps_i,
  output logic             done_o,
  output logic [NumW-1:0]  quot_o
);

  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic [DenW-1:0]  rem_q, den_q;
  logic [NumW-1:0]  num_q, quot_q;
  logic [DenW:0]    rem2, diff;
  logic             ge;

  // The remainder always stays below the divisor, so the shifted value
  // fits in one extra bit.
  assign rem2   = {rem_q, num_q[NumW-1]};
  assign ge     = rem2 >= {1'b0, den_q};
  assign diff   = rem2 - {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      num_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DenW-1:0] : rem2[DenW-1:0];
      num_q  <= num_q << 1;
      quot_q <= {quot_q[NumW-2:0], ge};
    end
  end

endmodule

FILE: sv/ske_back.sv
// Back end: two passes over the stored series, the kurtosis and deviation
// arithmetic, and the result register. Depends on ske_pkg and ske_div.
module ske_back #(
  parameter int unsigned MAX_SAMPLES = ske_pkg::MaxSamplesDef,
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AddrW = $clog2(MAX_SAMPLES),
  localparam int unsigned SumW  = ske_pkg::SampleW + CntW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_empty_i,
  output logic                               job_pop_o,
  input  logic [CntW-1:0]                    job_n_i,
  input  logic signed [SumW-1:0]             job_s_i,
  output logic [AddrW-1:0]                   rd_addr_o,
  input  logic signed [ske_pkg::SampleW-1:0] rd_data_i,
  output logic                               release_o,
  output logic                               out_empty_o,
  input  logic                               out_pop_i,
  output ske_pkg::out_item_t                 out_item_o
);

  localparam int unsigned RW       = ske_pkg::ResW;
  localparam int unsigned GW       = 2 * RW;
  localparam int unsigned PxW      = CntW + ske_pkg::SampleW + 1;
  localparam int unsigned AdW      = ske_pkg::SampleW + CntW;
  localparam int unsigned SqW      = 2 * AdW;
  localparam int unsigned QW       = SqW + CntW;
  localparam int unsigned QtW      = QW + RW;
  localparam int unsigned MW       = 2 * CntW;
  localparam int unsigned AccW     = GW + MW;
  localparam int unsigned NumW     = AccW + CntW;
  localparam int unsigned DenShift = 48;
  localparam int unsigned TW       = NumW + 1 - DenShift;
  localparam int unsigned PadW     = QtW - TW;
  localparam int unsigned NnW      = 3 * CntW;
  localparam int unsigned McW      = $clog2(MW + 1);
  localparam int unsigned StepW    = $clog2(QtW + 1);
  localparam int unsigned ScW      = $clog2(RW + 1);
  localparam int unsigned SrW      = RW + 2;
  localparam int unsigned MinN     = 4;
  localparam int unsigned ExcessOff = 3;

  typedef enum logic [4:0] {
    S_IDLE, S_P1, S_P1W, S_CHK, S_P2RD, S_P2W, S_P2DV, S_P2SQ, S_K0, S_K1,
    S_MA, S_KAB, S_MN, S_KT, S_KDV, S_VDV, S_SQ, S_OUT
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        n_q, idx_q, nm1;
  logic signed [SumW-1:0] s_q;
  logic [3:0]             vpipe_q;
  logic [QW-1:0]          q_q;
  logic [GW-1:0]          g_q, rr_q;
  logic [MW-1:0]          n2_q, mm_q, e_q, ms_q;
  logic [NnW-1:0]         nn1_q;
  logic [NumW-1:0]        acc_q, xs_q;
  logic [McW-1:0]         mc_q;
  logic                   neg_q, err_q;
  logic [RW-1:0]          kurt_q, root_q;
  logic [GW-1:0]          vs_q;
  logic [SrW-1:0]         sqr_q;
  logic [ScW-1:0]         sc_q;
  logic                   out_valid_q;
  ske_pkg::out_item_t     out_q;

  // Deviation datapath, free running behind the store read port.
  logic signed [PxW-1:0]  px_q, d_w, dn_w;
  logic [AdW-1:0]         ad_q;
  logic [SqW-1:0]         sq_q;

  logic                   issue, out_room;
  logic                   div_start, div_done;
  logic [QW-1:0]          div_rem, div_den;
  logic [QtW-1:0]         div_num, div_quot;
  logic [StepW-1:0]       div_steps;

  logic [AccW-1:0]        a_w, b_w, mag_w;
  logic [CntW+1:0]        bb_w;
  logic                   neg_w;
  logic [NumW:0]          rnd_w;
  logic [TW-1:0]          t_w;
  logic                   res_hi, pos_sat, neg_sat;
  logic [RW-1:0]          kurt_w;
  logic [SrW+1:0]         sr2_w, trial_w, srd_w;
  logic                   sr_ge;

  assign nm1       = n_q - 1'b1;
  assign issue     = (state_q == S_P1) || (state_q == S_P2RD);
  assign rd_addr_o = idx_q[AddrW-1:0];
  assign job_pop_o = (state_q == S_IDLE) && !job_empty_i;
  assign out_room  = !out_valid_q || out_pop_i;
  assign release_o = (state_q == S_OUT) && out_room;
  assign out_empty_o = !out_valid_q;
  assign out_item_o  = out_q;

  assign d_w  = px_q - PxW'(s_q);
  assign dn_w = -d_w;

  always_ff @(posedge clk_i) begin
    px_q <= $signed({1'b0, n_q}) * rd_data_i;
    ad_q <= d_w[PxW-1] ? dn_w[AdW-1:0] : d_w[AdW-1:0];
    sq_q <= ad_q * ad_q;
    rr_q <= div_quot[RW-1:0] * div_quot[RW-1:0];
  end

  // Divider operands: one deviation quotient per sample in the second pass,
  // then the kurtosis division, then the variance division.
  always_comb begin
    div_rem   = QW'(sq_q);
    div_num   = '0;
    div_den   = q_q;
    div_steps = StepW'(RW);
    if (state_q == S_KT) begin
      div_rem   = '0;
      div_num   = {t_w, {PadW{1'b0}}};
      div_den   = QW'(e_q);
      div_steps = StepW'(TW);
    end else if (state_q == S_KDV) begin
      div_rem   = '0;
      div_num   = {q_q, {RW{1'b0}}};
      div_den   = QW'(nn1_q);
      div_steps = StepW'(QtW);
    end
  end

  assign div_start = ((state_q == S_P2W) && vpipe_q[3]) || (state_q == S_KT) ||
                     ((state_q == S_KDV) && div_done);

  ske_div #(
    .NumW (QtW),
    .DenW (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // n(n+1)G against 3(n-1), both as Q22.64 at the default store size.
  assign bb_w  = (CntW + 2)'(nm1) * (CntW + 2)'(ExcessOff);
  assign a_w   = acc_q[AccW-1:0];
  assign b_w   = AccW'({bb_w, {GW{1'b0}}});
  assign neg_w = a_w < b_w;
  assign mag_w = neg_w ? b_w - a_w : a_w - b_w;

  // Dividing by (n-2)(n-3)*2^48 is a shift followed by a small division,
  // with half the divisor added first for rounding.
  assign rnd_w = {1'b0, acc_q} + (NumW + 1)'({e_q, {(DenShift - 1){1'b0}}});
  assign t_w   = rnd_w[NumW:DenShift];

  assign res_hi  = |div_quot[QtW-1:RW];
  assign pos_sat = res_hi || div_quot[RW-1];
  assign neg_sat = res_hi || (div_quot[RW-1] && |div_quot[RW-2:0]);
  always_comb begin
    if (neg_q) begin
      kurt_w = neg_sat ? {1'b1, {(RW - 1){1'b0}}} : RW'(0) - div_quot[RW-1:0];
    end else begin
      kurt_w = pos_sat ? {1'b0, {(RW - 1){1'b1}}} : div_quot[RW-1:0];
    end
  end

  // Integer square root, two radicand bits per step.
  assign sr2_w   = {sqr_q, vs_q[GW-1:GW-2]};
  assign trial_w = {2'b00, root_q, 2'b01};
  assign sr_ge   = sr2_w >= trial_w;
  assign srd_w   = sr2_w - trial_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      s_q         <= '0;
      idx_q       <= '0;
      vpipe_q     <= '0;
      q_q         <= '0;
      g_q         <= '0;
      n2_q        <= '0;
      mm_q        <= '0;
      e_q         <= '0;
      nn1_q       <= '0;
      acc_q       <= '0;
      xs_q        <= '0;
      ms_q        <= '0;
      mc_q        <= '0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      kurt_q      <= '0;
      root_q      <= '0;
      vs_q        <= '0;
      sqr_q       <= '0;
      sc_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      vpipe_q <= {vpipe_q[2:0], issue};
      if (vpipe_q[3] && ((state_q == S_P1) || (state_q == S_P1W))) begin
        q_q <= q_q + QW'(sq_q);
      end
      if ((state_q == S_OUT) && out_room) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (!job_empty_i) begin
            n_q   <= job_n_i;
            s_q   <= job_s_i;
            idx_q <= '0;
            q_q   <= '0;
            g_q   <= '0;
            if (job_n_i < CntW'(MinN)) begin
              kurt_q  <= '0;
              root_q  <= '0;
              err_q   <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_P1;
            end
          end
        end
        S_P1: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == nm1) begin
            idx_q   <= '0;
            state_q <= S_P1W;
          end
        end
        S_P1W: begin
          if (vpipe_q == '0) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (q_q == '0) begin
            kurt_q  <= '0;
            root_q  <= '0;
            err_q   <= 1'b1;
            state_q <= S_OUT;
          end else begin
            err_q   <= 1'b0;
            state_q <= S_P2RD;
          end
        end
        S_P2RD: begin
          state_q <= S_P2W;
        end
        S_P2W: begin
          if (vpipe_q[3]) begin
            state_q <= S_P2DV;
          end
        end
        S_P2DV: begin
          if (div_done) begin
            state_q <= S_P2SQ;
          end
        end
        S_P2SQ: begin
          g_q <= g_q + rr_q;
          if (idx_q == nm1) begin
            state_q <= S_K0;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_P2RD;
          end
        end
        S_K0: begin
          n2_q    <= MW'(n_q) * MW'(n_q);
          mm_q    <= MW'(n_q) * (MW'(n_q) + MW'(1));
          e_q     <= MW'(n_q - CntW'(2)) * MW'(n_q - CntW'(3));
          state_q <= S_K1;
        end
        S_K1: begin
          nn1_q   <= NnW'(n2_q) * NnW'(nm1);
          acc_q   <= '0;
          xs_q    <= NumW'(g_q);
          ms_q    <= mm_q;
          mc_q    <= McW'(MW);
          state_q <= S_MA;
        end
        S_MA, S_MN: begin
          acc_q <= acc_q + (ms_q[0] ? xs_q : '0);
          xs_q  <= xs_q << 1;
          ms_q  <= ms_q >> 1;
          mc_q  <= mc_q - 1'b1;
          if (mc_q == McW'(1)) begin
            state_q <= (state_q == S_MA) ? S_KAB : S_KT;
          end
        end
        S_KAB: begin
          xs_q    <= NumW'(mag_w);
          neg_q   <= neg_w;
          acc_q   <= '0;
          ms_q    <= MW'(nm1);
          mc_q    <= McW'(CntW);
          state_q <= S_MN;
        end
        S_KT: begin
          state_q <= S_KDV;
        end
        S_KDV: begin
          if (div_done) begin
            kurt_q  <= kurt_w;
            state_q <= S_VDV;
          end
        end
        S_VDV: begin
          if (div_done) begin
            if (|div_quot[QtW-1:GW]) begin
              root_q  <= '1;
              state_q <= S_OUT;
            end else begin
              vs_q    <= div_quot[GW-1:0];
              sqr_q   <= '0;
              root_q  <= '0;
              sc_q    <= ScW'(RW);
              state_q <= S_SQ;
            end
          end
        end
        S_SQ: begin
          sqr_q  <= sr_ge ? srd_w[SrW-1:0] : sr2_w[SrW-1:0];
          root_q <= {root_q[RW-2:0], sr_ge};
          vs_q   <= vs_q << 2;
          sc_q   <= sc_q - 1'b1;
          if (sc_q == ScW'(1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_room) begin
            out_q.kurt    <= kurt_q;
            out_q.std_dev <= root_q;
            out_q.error   <= err_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sample_excess_kurtosis.sv
// Unbiased sample excess kurtosis of one stream of signed 16-bit samples.
// Input queue: drive an item on in_item_i with push; it is taken at an edge
// where push is high and full is low. The item with last set closes a series.
// Samples load at one per cycle while full is low. After the last item, full
// stays high while the back end works on the stored series: one pass forms
// the squared-deviation sum, then a second pass divides each sample's squared
// deviation by that sum on the shared one-bit-per-cycle divider, followed by
// two long divisions and a 32-step square root.
// Result queue: while empty is low, out_item_o carries kurtosis and standard
// deviation in Q16.16 plus the error flag; pop takes it at an edge where empty
// is low. The result sits in an output register, so the next series loads as
// soon as the result is written there, even if the receiver stalls.
// Reset clears the count, the running sum and all control state; the sample
// store needs no clearing since only entries of the open series are read.
// Depends on ske_pkg, ske_front, ske_fifo, ske_div and ske_back.
module sample_excess_kurtosis #(
  parameter int unsigned MAX_SAMPLES = ske_pkg::MaxSamplesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  ske_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output ske_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AddrW = $clog2(MAX_SAMPLES);
  localparam int unsigned SumW  = ske_pkg::SampleW + CntW;
  localparam int unsigned JobW  = CntW + SumW;

  logic                               job_push, job_full, job_empty, job_pop;
  logic [CntW-1:0]                    job_n_in, job_n_out;
  logic signed [SumW-1:0]             job_s_in, job_s_out;
  logic [JobW-1:0]                    job_out;
  logic [AddrW-1:0]                   rd_addr;
  logic signed [ske_pkg::SampleW-1:0] rd_data;
  logic                               rel;

  ske_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .job_push_o (job_push),
    .job_n_o    (job_n_in),
    .job_s_o    (job_s_in),
    .job_full_i (job_full),
    .release_i  (rel)
  );

  ske_fifo #(
    .W (JobW)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({job_n_in, job_s_in}),
    .full_o  (job_full),
    .empty_o (job_empty),
    .pop_i   (job_pop),
    .data_o  (job_out)
  );

  assign job_n_out = job_out[JobW-1:SumW];
  assign job_s_out = job_out[SumW-1:0];

  ske_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_n_i     (job_n_out),
    .job_s_i     (job_s_out),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .release_o   (rel),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: sv/ske_checker.sv
// Port-level checks for the sample excess kurtosis block, bound to its top
// level. Depends on ske_pkg and sample_excess_kurtosis.
module ske_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input ske_pkg::in_item_t  in_item_i,
  input ske_pkg::out_item_t out_item_o
);

  // Only the last item of a series closes the input side.
  a_mid_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !in_item_i.last) |=> !full)
    else $error("input stalled after an item that was not last");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_item_i.last) |=> full)
    else $error("input not held off after the last item of a series");

  // A new result only appears while a series was being worked on.
  a_result_from_series: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(full))
    else $error("result appeared with no series in flight");

  // The input side reopens only once the result is waiting.
  a_reopen_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(full) |-> !empty)
    else $error("input reopened without a waiting result");

endmodule

bind sample_excess_kurtosis ske_checker u_ske_checker (.*);

FILE: test/sample_excess_kurtosis_tb.sv
// Testbench for sample_excess_kurtosis: sends sample series through the input
// queue, predicts each closing result in SystemVerilog and checks every field.
// Depends on ske_pkg and the sample_excess_kurtosis RTL.
module sample_excess_kurtosis_tb;

  localparam int unsigned MaxSamples = ske_pkg::MaxSamplesDef;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 400;

  typedef enum int unsigned {
    PatFull,
    PatNarrow,
    PatConst,
    PatSpike,
    PatExtreme
  } pattern_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  ske_pkg::in_item_t  in_item = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  ske_pkg::out_item_t out_item;

  // Open series as seen by the predictor.
  int          series_buf [MaxSamples];
  int unsigned series_len = 0;
  longint      series_sum = 0;

  ske_pkg::out_item_t expected_q [$];
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  int unsigned hold_off = 0;
  int unsigned stall_left = 0;

  sample_excess_kurtosis dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push),
    .in_item_i (in_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  always #2 clk = ~clk;

  // Statistics of the closed series, in the same fixed-point steps as the block.
  function automatic ske_pkg::out_item_t kurtosis_of_series();
    ske_pkg::out_item_t res;
    int unsigned  n;
    longint       d;
    logic [63:0]  ad, r, g, c, m, root;
    logic [127:0] q, a, b, mag, num, den, quot, v;
    bit           neg;
    res = '0;
    res.error = 1'b1;
    n = series_len;
    q = '0;
    g = '0;
    if (n >= 4) begin
      for (int i = 0; i < n; i++) begin
        d = longint'(n) * series_buf[i] - series_sum;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        q = q + 128'(ad) * 128'(ad);
      end
    end
    if (n >= 4 && q != 0) begin
      res.error = 1'b0;
      for (int i = 0; i < n; i++) begin
        d = longint'(n) * series_buf[i] - series_sum;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        r = 64'(((128'(ad) * 128'(ad)) << 32) / q);
        g = g + r * r;
      end
      a = 128'(g) * (128'(n) * 128'(n + 1));
      b = 128'(3 * (n - 1)) << 64;
      neg = a < b;
      mag = neg ? b - a : a - b;
      num = mag * 128'(n - 1);
      den = 128'((n - 2) * (n - 3)) << 48;
      quot = (num + (den >> 1)) / den;
      if (neg) begin
        m = (quot[127:64] != 0 || quot[63:0] > 64'h8000_0000) ? 64'h8000_0000 : quot[63:0];
        res.kurt = 32'(-m);
      end else begin
        res.kurt = (quot[127:64] != 0 || quot[63:0] > 64'h7FFF_FFFF) ?
                   32'h7FFF_FFFF : quot[31:0];
      end
      v = (q << 32) / (128'(n) * 128'(n) * 128'(n - 1));
      root = '0;
      for (int bt = 63; bt >= 0; bt--) begin
        c = root | (64'd1 << bt);
        if (v >= 128'(c) * 128'(c)) root = c;
      end
      res.std_dev = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    end
    return res;
  endfunction

  function automatic void accept_sample(ske_pkg::in_item_t it);
    if (series_len < MaxSamples) begin
      series_buf[series_len] = it.sample;
      series_sum += it.sample;
      series_len++;
    end
    if (it.last) begin
      expected_q.push_back(kurtosis_of_series());
      series_len = 0;
      series_sum = 0;
    end
  endfunction

  // Push stays high after the item is taken; an idle burst lowers it first.
  task automatic send_item(logic signed [15:0] smp, logic lst);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item.sample <= smp;
    in_item.last <= lst;
    do @(posedge clk); while (full);
    accept_sample(in_item);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample(pattern_e pat, int base);
    case (pat)
      PatFull:    return 16'($urandom);
      PatNarrow:  return 16'(base + $signed($urandom_range(0, 20)) - 10);
      PatConst:   return 16'(base);
      PatSpike:   return ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                         16'(base + $signed($urandom_range(0, 4)) - 2);
      default:    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic send_series(int unsigned len, pattern_e pat);
    int base;
    base = $signed(16'($urandom)) / 2;
    for (int i = 0; i < len; i++) send_item(pick_sample(pat, base), i == len - 1);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(16'sh7FFF, 1'b1);                  // single sample
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);                  // two samples
    send_item(16'sh0001, 1'b0);
    send_item(16'sh0002, 1'b0);
    send_item(16'sh0003, 1'b1);                  // three samples
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);                  // four samples at the extremes
    send_series(5, PatConst);                    // zero deviation
    send_item(16'sh0000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh7FFF, 1'b1);                  // one outlier, large kurtosis
    stop_sending();
  endtask

  // Samples past the store size are dropped; the last mark still closes.
  task automatic test_store_full();
    send_series(MaxSamples + 6, PatFull);
    stop_sending();
  endtask

  task automatic test_backpressure();
    hold_off = 3000;
    for (int s = 0; s < 5; s++) send_series(6, PatSpike);
    stop_sending();
  endtask

  task automatic test_random(int unsigned n_items, bit with_idle);
    int unsigned sent, sel, len;
    pattern_e    pat;
    send_idle = with_idle;
    recv_idle = with_idle;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      len = $urandom_range(4, 16);
      pat = PatFull;
      if (sel < 10) len = $urandom_range(1, 3);
      else if (sel < 15) pat = PatConst;
      else if (sel < 35) pat = PatNarrow;
      else if (sel < 55) pat = PatSpike;
      else if (sel < 60) pat = PatExtreme;
      else if (sel < 63) len = $urandom_range(30, 80);
      send_series(len, pat);
      sent += len;
    end
    stop_sending();
  endtask

  // Sender waits for every outstanding result before going on.
  task automatic test_drain_pause();
    wait_drained();
    send_series(7, PatFull);
    stop_sending();
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("sample_excess_kurtosis_tb: FAIL");
      $finish;
    end
  end

  // Result check and receiver stall pattern.
  always @(posedge clk) begin
    ske_pkg::out_item_t exp_item;
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kurt=%h std_dev=%h error=%b", $time,
                 out_item.kurt, out_item.std_dev, out_item.error);
        error_cnt++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_item.kurt !== exp_item.kurt) begin
          $display("%0t: kurt expected %h actual %h", $time, exp_item.kurt, out_item.kurt);
          error_cnt++;
        end
        if (out_item.std_dev !== exp_item.std_dev) begin
          $display("%0t: std_dev expected %h actual %h", $time,
                   exp_item.std_dev, out_item.std_dev);
          error_cnt++;
        end
        if (out_item.error !== exp_item.error) begin
          $display("%0t: error expected %b actual %b", $time,
                   exp_item.error, out_item.error);
          error_cnt++;
        end
      end
    end
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_store_full();
    test_backpressure();
    test_random(100, 1'b1);
    test_drain_pause();
    test_random(40, 1'b0);
    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("sample_excess_kurtosis_tb: PASS");
    end else begin
      $display("sample_excess_kurtosis_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ske_pkg.sv
sv/ske_front.sv
sv/ske_fifo.sv
sv/ske_div.sv
sv/ske_back.sv
sv/sample_excess_kurtosis.sv
sv/ske_checker.sv
test/sample_excess_kurtosis_tb.sv
